/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion helper macros for the combination enumerator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/comb_enum_pkg.sv */
// ----------------------------------------------------------------------------
// comb_enum_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package comb_enum_pkg;

	localparam int MAX_ITEMS  = 16;
	localparam int MAX_CHOOSE = 8;

	localparam int FUNC_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int VALUE_W    = 32;
	localparam int POS_W      = 3;
	localparam int N_W        = 5;
	localparam int K_W        = 4;
	localparam int COUNT_W    = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;
	localparam logic [N_W-1:0]     N_RESET   = 5'd10;
	localparam logic [K_W-1:0]     K_RESET   = 4'd4;

	// input item kinds
	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADV,
		ST_EMIT,
		ST_EXH
	} ctrl_state_t;

	typedef struct packed {
		logic store_wr;
		logic rewind;
		logic step;
		logic mark_done;
		logic emit_elem;
		logic emit_exh;
	} ctrl_cmd_t;

	typedef struct packed {
		logic adv_ok;
		logic last_pos;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/comb_enum_ctrl.sv */
// ----------------------------------------------------------------------------
// comb_enum_ctrl
// sequencer: takes input transactions, steps the index set, emits elements
// ----------------------------------------------------------------------------
module comb_enum_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [comb_enum_pkg::FUNC_W-1:0]       in_func,
	output logic                                   in_ready,
	input  comb_enum_pkg::dp_status_t              status,
	output comb_enum_pkg::ctrl_cmd_t               cmd
);
	import comb_enum_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_func == FUNC_NEXT)) state_d = ST_ADV;
			end
			ST_ADV: begin
				state_d = status.adv_ok ? ST_EMIT : ST_EXH;
			end
			ST_EMIT: begin
				if (status.out_free && status.last_pos) state_d = ST_IDLE;
			end
			ST_EXH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.store_wr = accept && (in_func == FUNC_LOAD);
				cmd.rewind   = accept && (in_func == FUNC_RESTART);
			end
			ST_ADV: begin
				cmd.step      = status.adv_ok;
				cmd.mark_done = !status.adv_ok;
			end
			ST_EMIT: begin
				cmd.emit_elem = status.out_free;
			end
			ST_EXH: begin
				cmd.emit_exh = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/comb_enum_dp.sv */
// ----------------------------------------------------------------------------
// comb_enum_dp
// value store, index set with next-combination rule, counters, output register
// ----------------------------------------------------------------------------
module comb_enum_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  comb_enum_pkg::ctrl_cmd_t               cmd,
	output comb_enum_pkg::dp_status_t              status,
	input  logic [comb_enum_pkg::SLOT_W-1:0]       in_slot,
	input  logic [comb_enum_pkg::VALUE_W-1:0]      in_value,
	input  logic                                   cfg_wr,
	input  logic [comb_enum_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [comb_enum_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [comb_enum_pkg::VALUE_W-1:0]      out_value,
	output logic [comb_enum_pkg::SLOT_W-1:0]       out_slot,
	output logic [comb_enum_pkg::POS_W-1:0]        out_pos,
	output logic                                   out_last,
	output logic                                   out_exh,
	output logic [comb_enum_pkg::COUNT_W-1:0]      out_number
);
	import comb_enum_pkg::*;

	logic [N_W-1:0]     item_count_q;
	logic [K_W-1:0]     choose_count_q;
	logic [VALUE_W-1:0] value_store [MAX_ITEMS];
	logic [SLOT_W-1:0]  chosen_q [MAX_CHOOSE];
	logic [SLOT_W-1:0]  next_idx [MAX_CHOOSE];
	logic               started_q;
	logic               done_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;

	logic [N_W-1:0]     n_sat;
	logic [N_W-1:0]     k_ext;
	logic               k_ok;
	logic               found;
	logic [POS_W-1:0]   fidx;
	logic [SLOT_W-1:0]  fval;
	logic [N_W-1:0]     lim;
	logic               rewind;
	logic               out_free;

	assign rewind = cmd.rewind ||
		(cfg_wr && ((cfg_idx == CFG_ITEM_COUNT) || (cfg_idx == CFG_CHOOSE_COUNT)));

	assign n_sat = (item_count_q > N_W'(MAX_ITEMS)) ? N_W'(MAX_ITEMS) : item_count_q;
	assign k_ext = {1'b0, choose_count_q};
	assign k_ok  = (choose_count_q != '0) && (k_ext <= N_W'(MAX_CHOOSE)) && (k_ext <= n_sat);

	// rightmost index still below its ceiling n - k + i
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		fval  = '0;
		lim   = '0;
		for (int i = 0; i < MAX_CHOOSE; i++) begin
			lim = n_sat - k_ext + N_W'(i);
			if ((N_W'(i) < k_ext) && ({1'b0, chosen_q[i]} < lim)) begin
				found = 1'b1;
				fidx  = POS_W'(i);
				fval  = chosen_q[i];
			end
		end
	end

	// refill: index j takes fval + 1 + (j - fidx)
	always_comb begin
		for (int j = 0; j < MAX_CHOOSE; j++) begin
			next_idx[j] = SLOT_W'({1'b0, fval} + N_W'(1) + N_W'(j) - {2'b00, fidx});
		end
	end

	assign out_free        = !out_valid_q || out_ready;
	assign status.adv_ok   = !done_q && k_ok && (!started_q || found);
	assign status.last_pos = ((K_W'(pos_q) + K_W'(1)) == choose_count_q);
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q   <= N_RESET;
			choose_count_q <= K_RESET;
		end else if (cfg_wr) begin
			if (cfg_idx == CFG_ITEM_COUNT)   item_count_q   <= cfg_wdata;
			if (cfg_idx == CFG_CHOOSE_COUNT) choose_count_q <= cfg_wdata[K_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr) value_store[in_slot] <= in_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_CHOOSE; j++) chosen_q[j] <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
			pos_q     <= '0;
		end else if (rewind) begin
			for (int j = 0; j < MAX_CHOOSE; j++) chosen_q[j] <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			if (cmd.step) begin
				for (int j = 0; j < MAX_CHOOSE; j++) begin
					if (!started_q) chosen_q[j] <= SLOT_W'(j);
					else if (POS_W'(j) >= fidx) chosen_q[j] <= next_idx[j];
				end
				started_q <= 1'b1;
				pos_q     <= '0;
				if (count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
			end
			if (cmd.mark_done) done_q <= 1'b1;
			if (cmd.emit_elem) pos_q <= pos_q + POS_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_elem || cmd.emit_exh) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_elem) begin
			out_value  <= value_store[chosen_q[pos_q]];
			out_slot   <= chosen_q[pos_q];
			out_pos    <= pos_q;
			out_last   <= status.last_pos;
			out_exh    <= 1'b0;
			out_number <= count_q;
		end else if (cmd.emit_exh) begin
			out_value  <= '0;
			out_slot   <= '0;
			out_pos    <= '0;
			out_last   <= 1'b1;
			out_exh    <= 1'b1;
			out_number <= count_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/combination_enumerator_core.sv */
// ----------------------------------------------------------------------------
// combination_enumerator_core: lexicographic k-combination generator
// flow: an accepted next transaction passes the advance state, then the emit
// or exhausted state; one element per cycle leaves the output register while
// m_tready is high; input, load and restart are taken only in the idle state
// reset: arst_n clears n to 10, k to 4, the index set and counters; values kept
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module combination_enumerator_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// input stream
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [comb_enum_pkg::IN_DATA_W-1:0]       s_tdata,  // slot[3:0], value[35:4], zero fill
	input  logic [comb_enum_pkg::FUNC_W-1:0]          s_tuser,  // func[1:0]
	// result stream
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [comb_enum_pkg::OUT_DATA_W-1:0]      m_tdata,  // element_value[31:0],
	                                                            // element_slot[35:32],
	                                                            // position[38:36],
	                                                            // combination_number[52:39],
	                                                            // zero fill
	output logic                                      m_tlast,  // last_element
	output logic                                      m_tuser,  // exhausted
	// configuration write channel
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [comb_enum_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [comb_enum_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import comb_enum_pkg::*;

	ctrl_cmd_t          cmd;
	dp_status_t         status;
	logic [VALUE_W-1:0] out_value;
	logic [SLOT_W-1:0]  out_slot;
	logic [POS_W-1:0]   out_pos;
	logic [COUNT_W-1:0] out_number;

	// configuration is taken in any cycle; a write to the item or choose count also rewinds the enumeration
	assign cfg_ready = 1'b1;

	// sequencer: idle / advance / emit elements / emit exhausted
	comb_enum_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: value slots, index set, counters and the result register
	comb_enum_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_slot    (s_tdata[SLOT_W-1:0]),
		.in_value   (s_tdata[SLOT_W+VALUE_W-1:SLOT_W]),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (out_value),
		.out_slot   (out_slot),
		.out_pos    (out_pos),
		.out_last   (m_tlast),
		.out_exh    (m_tuser),
		.out_number (out_number)
	);

	// result packing, first field in the low bits
	assign m_tdata = {3'b000, out_number, out_pos, out_slot, out_value};

	// an exhausted result always closes its transaction group
	`ASSERT_SAME(a_exh_is_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)

	// while input is taken, any pending result must be the final one of its group
	`ASSERT_SAME(a_idle_only_last, clk, arst_n, m_tvalid && s_tready, m_tlast)

	// elements of one combination follow back to back with rising positions
	`ASSERT_NEXT(a_pos_step, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && (out_pos == $past(out_pos) + 3'd1))

endmodule
